>>> rtl/ect_pkg.sv
// ----------------------------------------------------------------------------
// Ear-clip triangulator package
// Shared payload types, codes and default sizes for the triangulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ect_pkg;

  localparam int MAX_POINTS_DEF  = 32;
  localparam int COORD_BITS_DEF  = 16;
  localparam int PT_W            = 16;
  localparam int OUT_IDX_W       = 5;

  typedef enum logic [1:0] {
    OUT_COMPLETE = 2'd0,
    OUT_FEW      = 2'd1,
    OUT_DEGEN    = 2'd2,
    OUT_OVERFLOW = 2'd3
  } outcome_t;

  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic                   final_point;
  } in_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] first_index;
    logic [OUT_IDX_W-1:0] second_index;
    logic [OUT_IDX_W-1:0] third_index;
    logic                 has_triangle;
    logic                 end_of_run;
    outcome_t             outcome;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_ROT_L,
    OP_ROT_R,
    OP_DEL1,
    OP_HEAD
  } cell_op_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_E0,
    EV_E1,
    EV_E2
  } eval_t;

  typedef struct packed {
    cell_op_t op;
    eval_t    ev;
    logic     set_head0;
    logic     set_head1;
  } cell_ctrl_t;

endpackage

>>> rtl/ect_cell.sv
// ----------------------------------------------------------------------------
// Ear-clip vertex cell
// Holds one remaining vertex, moves it along the ring and tests it against
// the broadcast triangle edges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ect_cell #(
  parameter int MAX_POINTS = ect_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = ect_pkg::COORD_BITS_DEF,
  parameter int POS        = 0
) (
  input  logic                                 clk,
  input  ect_pkg::cell_ctrl_t                  ctrl,
  input  logic [$clog2(MAX_POINTS+1)-1:0]      cnt,
  input  logic [$clog2(MAX_POINTS)-1:0]        wr_idx,
  input  logic [$clog2(MAX_POINTS)-1:0]        head_idx,
  input  logic signed [COORD_BITS-1:0]         in_x,
  input  logic signed [COORD_BITS-1:0]         in_y,
  input  logic signed [COORD_BITS-1:0]         ax,
  input  logic signed [COORD_BITS-1:0]         ay,
  input  logic signed [COORD_BITS-1:0]         bx,
  input  logic signed [COORD_BITS-1:0]         by,
  input  logic [$clog2(MAX_POINTS)+2*COORD_BITS:0] left,
  input  logic [$clog2(MAX_POINTS)+2*COORD_BITS:0] right,
  input  logic [$clog2(MAX_POINTS)+2*COORD_BITS:0] first,
  input  logic [$clog2(MAX_POINTS)+2*COORD_BITS:0] last,
  output logic [$clog2(MAX_POINTS)+2*COORD_BITS:0] data,
  output logic                                 enclosed,
  output logic                                 convex
);

  localparam int C     = COORD_BITS;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int DW    = 1 + IDX_W + 2 * C;
  localparam int PW    = 2 * C + 2;
  localparam int VW    = 2 * C + 3;

  logic [DW-1:0]         data_next;
  logic [IDX_W-1:0]      idx;
  logic signed [C-1:0]   x;
  logic signed [C-1:0]   y;
  logic signed [C:0]     dx;
  logic signed [C:0]     dy;
  logic signed [C:0]     kx;
  logic signed [C:0]     ky;
  logic signed [PW-1:0]  p1;
  logic signed [PW-1:0]  p2;
  logic signed [VW-1:0]  v;
  logic                  ge0;
  logic                  ge1;
  logic                  ge2;

  assign idx = data[DW-2 -: IDX_W];
  assign x   = $signed(data[2*C-1:C]);
  assign y   = $signed(data[C-1:0]);

  always_comb begin
    data_next = data;
    case (ctrl.op)
      ect_pkg::OP_LOAD: begin
        if (wr_idx == IDX_W'(POS)) begin
          data_next = {1'b0, wr_idx, in_x, in_y};
        end
      end
      ect_pkg::OP_ROT_L: begin
        if (cnt == CNT_W'(POS + 1)) begin
          data_next = first;
        end else begin
          data_next = right;
        end
      end
      ect_pkg::OP_ROT_R: begin
        if (POS == 0) begin
          data_next = last;
        end else begin
          data_next = left;
        end
      end
      ect_pkg::OP_DEL1: begin
        if (POS == 0) begin
          data_next[DW-1] = data[DW-1] | ctrl.set_head0;
        end else begin
          data_next = right;
          data_next[DW-1] = right[DW-1] | ((POS == 1) && ctrl.set_head1);
        end
      end
      ect_pkg::OP_HEAD: begin
        data_next[DW-1] = (idx == head_idx);
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  assign dx = (C+1)'(bx) - (C+1)'(ax);
  assign dy = (C+1)'(by) - (C+1)'(ay);
  assign kx = (C+1)'(x) - (C+1)'(ax);
  assign ky = (C+1)'(y) - (C+1)'(ay);
  assign v  = VW'(p1) - VW'(p2);

  always_ff @(posedge clk) begin
    data <= data_next;
    p1   <= dx * ky;
    p2   <= dy * kx;
    case (ctrl.ev)
      ect_pkg::EV_E0: begin
        ge0    <= !v[VW-1];
        convex <= !v[VW-1] && (v != '0);
      end
      ect_pkg::EV_E1: ge1 <= !v[VW-1];
      ect_pkg::EV_E2: ge2 <= !v[VW-1];
      default: begin
      end
    endcase
  end

  assign enclosed = ge0 && ge1 && ge2;

endmodule

>>> rtl/ear_clip_triangulator.sv
// ----------------------------------------------------------------------------
// Ear-clip triangulator
// Stores polygon vertices and reports an ear-clipping triangulation.
// ----------------------------------------------------------------------------
// Vertices enter one transaction per cycle while a polygon is loaded; the
// transaction marked final starts triangulation and holds off input until the
// last result of the polygon has been queued. The remaining vertices sit in a
// ring of cells, one vertex each, that rotates to bring every candidate corner
// to the first three cells; all cells test themselves against the candidate
// triangle at once, and after each clip the ring rotates back to the head of
// the walk.
`timescale 1ns / 1ps

module ear_clip_triangulator #(
  parameter int MAX_POINTS = ect_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = ect_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               vertex_valid,
  output logic               vertex_stall,
  input  ect_pkg::in_item_t  vertex,
  output logic               result_valid,
  input  logic               result_stall,
  output ect_pkg::out_item_t result
);

  localparam int C     = COORD_BITS;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int DW    = 1 + IDX_W + 2 * C;
  localparam int AW    = 2 * C + $clog2(MAX_POINTS) + 3;
  localparam int OIW   = ect_pkg::OUT_IDX_W;
  localparam int PW    = ect_pkg::PT_W;
  localparam logic [2:0] PH_DECIDE = 3'd4;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CLOSE,
    S_WIND,
    S_INIT,
    S_ALIGN,
    S_TEST,
    S_STAT
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       point_count;
  logic [CNT_W-1:0]       rem_cnt;
  logic [CNT_W-1:0]       scan;
  logic [CNT_W-1:0]       last_pos;
  logic signed [AW-1:0]   area;
  logic signed [AW-1:0]   term;
  logic signed [AW-1:0]   area_total;
  logic                   ovf;
  logic                   ccw;
  logic                   pend;
  logic                   pend_set;
  logic                   send;
  logic [2:0]             ph;
  ect_pkg::outcome_t      stat_code;
  logic signed [C-1:0]    prev_x;
  logic signed [C-1:0]    prev_y;
  logic signed [2*C-1:0]  pa;
  logic signed [2*C-1:0]  pb;
  logic signed [C-1:0]    in_x;
  logic signed [C-1:0]    in_y;
  logic signed [C-1:0]    mul_x;
  logic signed [C-1:0]    mul_y;
  logic [C+PW-1:0]        raw_x;
  logic [C+PW-1:0]        raw_y;
  logic                   accept;
  logic                   full;
  logic                   out_free;
  logic                   clip;
  logic                   blocked;
  logic                   last_scan;
  ect_pkg::cell_op_t      rot_op;
  ect_pkg::cell_ctrl_t    ctrl;
  logic [IDX_W-1:0]       head_idx;

  logic [DW-1:0]          cdata [MAX_POINTS];
  logic [DW-1:0]          lnb   [MAX_POINTS];
  logic [DW-1:0]          rnb   [MAX_POINTS];
  logic [MAX_POINTS-1:0]  cin;
  logic [MAX_POINTS-1:0]  ccvx;
  logic [MAX_POINTS-1:0]  tmask;

  logic [IDX_W-1:0]       i0;
  logic [IDX_W-1:0]       i1;
  logic [IDX_W-1:0]       i2;
  logic                   h1;
  logic signed [C-1:0]    x0, y0, x1, y1, x2, y2;
  logic signed [C-1:0]    tax, tay, tbx, tby, tcx, tcy;
  logic signed [C-1:0]    eax, eay, ebx, eby;

  assign raw_x = {{C{vertex.point_x[PW-1]}}, vertex.point_x};
  assign raw_y = {{C{vertex.point_y[PW-1]}}, vertex.point_y};
  assign in_x  = $signed(raw_x[C-1:0]);
  assign in_y  = $signed(raw_y[C-1:0]);

  assign vertex_stall = (state != S_LOAD);
  assign accept       = vertex_valid && !vertex_stall;
  assign full         = (point_count == CNT_W'(MAX_POINTS));
  assign out_free     = !result_valid || !result_stall;

  assign i0 = cdata[0][DW-2 -: IDX_W];
  assign i1 = cdata[1][DW-2 -: IDX_W];
  assign i2 = cdata[2][DW-2 -: IDX_W];
  assign h1 = cdata[1][DW-1];
  assign x0 = $signed(cdata[0][2*C-1:C]);
  assign y0 = $signed(cdata[0][C-1:0]);
  assign x1 = $signed(cdata[1][2*C-1:C]);
  assign y1 = $signed(cdata[1][C-1:0]);
  assign x2 = $signed(cdata[2][2*C-1:C]);
  assign y2 = $signed(cdata[2][C-1:0]);

  assign tax = ccw ? x0 : x2;
  assign tay = ccw ? y0 : y2;
  assign tbx = x1;
  assign tby = y1;
  assign tcx = ccw ? x2 : x0;
  assign tcy = ccw ? y2 : y0;

  always_comb begin
    case (ph)
      3'd1: begin
        eax = tbx; eay = tby; ebx = tcx; eby = tcy;
      end
      3'd2: begin
        eax = tcx; eay = tcy; ebx = tax; eby = tay;
      end
      default: begin
        eax = tax; eay = tay; ebx = tbx; eby = tby;
      end
    endcase
  end

  assign mul_x = (state == S_LOAD) ? in_x : x0;
  assign mul_y = (state == S_LOAD) ? in_y : y0;
  assign term  = AW'(pa) - AW'(pb);
  assign area_total = area + term;

  assign last_pos  = rem_cnt - CNT_W'(1);
  assign last_scan = (scan == last_pos);
  assign rot_op    = ccw ? ect_pkg::OP_ROT_L : ect_pkg::OP_ROT_R;
  assign head_idx  = ccw ? '0 : IDX_W'(point_count - CNT_W'(1));

  always_comb begin
    for (int j = 0; j < MAX_POINTS; j++) begin
      tmask[j] = (j >= 3) && (CNT_W'(j) < rem_cnt);
    end
  end

  assign blocked = |(cin & tmask);
  assign clip    = (ccw ? ccvx[2] : ccvx[0]) && !blocked;

  assign pend_set = ((state == S_LOAD) && accept && !full && (point_count != '0)) ||
                    ((state == S_CLOSE) && (point_count >= CNT_W'(3)));
  assign send     = out_free && (((state == S_ALIGN) && h1 && (rem_cnt == CNT_W'(3))) ||
                                 ((state == S_TEST) && (ph == PH_DECIDE) && clip) ||
                                 (state == S_STAT));

  always_comb begin
    ctrl = '{op: ect_pkg::OP_HOLD, ev: ect_pkg::EV_NONE, set_head0: 1'b0, set_head1: 1'b0};
    case (state)
      S_LOAD: begin
        if (accept && !full) begin
          ctrl.op = ect_pkg::OP_LOAD;
        end
      end
      S_INIT: ctrl.op = ect_pkg::OP_HEAD;
      S_ALIGN: begin
        if (!h1) begin
          ctrl.op = rot_op;
        end
      end
      S_TEST: begin
        case (ph)
          3'd1: ctrl.ev = ect_pkg::EV_E0;
          3'd2: ctrl.ev = ect_pkg::EV_E1;
          3'd3: ctrl.ev = ect_pkg::EV_E2;
          default: ctrl.ev = ect_pkg::EV_NONE;
        endcase
        if (ph == PH_DECIDE) begin
          if (clip && out_free) begin
            ctrl.op        = ect_pkg::OP_DEL1;
            ctrl.set_head0 = h1 && !ccw;
            ctrl.set_head1 = h1 && ccw;
          end else if (!clip && !last_scan) begin
            ctrl.op = rot_op;
          end
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    if (g == 0) begin : g_l0
      assign lnb[g] = '0;
    end else begin : g_ln
      assign lnb[g] = cdata[g-1];
    end
    if (g == MAX_POINTS - 1) begin : g_rl
      assign rnb[g] = '0;
    end else begin : g_rn
      assign rnb[g] = cdata[g+1];
    end

    ect_cell #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS),
      .POS        (g)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .cnt      (rem_cnt),
      .wr_idx   (point_count[IDX_W-1:0]),
      .head_idx (head_idx),
      .in_x     (in_x),
      .in_y     (in_y),
      .ax       (eax),
      .ay       (eay),
      .bx       (ebx),
      .by       (eby),
      .left     (lnb[g]),
      .right    (rnb[g]),
      .first    (cdata[0]),
      .last     (cdata[last_pos[IDX_W-1:0]]),
      .data     (cdata[g]),
      .enclosed (cin[g]),
      .convex   (ccvx[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      point_count  <= '0;
      rem_cnt      <= '0;
      area         <= '0;
      ovf          <= 1'b0;
      pend         <= 1'b0;
      ph           <= '0;
      scan         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (send) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      pend <= pend_set;
      if (pend) begin
        area <= area_total;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (!full) begin
              point_count <= point_count + CNT_W'(1);
              rem_cnt     <= point_count + CNT_W'(1);
              prev_x      <= in_x;
              prev_y      <= in_y;
              if (point_count != '0) begin
                pa <= prev_x * mul_y;
                pb <= mul_x * prev_y;
              end
            end else begin
              ovf <= 1'b1;
            end
            if (vertex.final_point) begin
              state <= S_CLOSE;
            end
          end
        end
        S_CLOSE: begin
          if (point_count < CNT_W'(3)) begin
            stat_code <= ovf ? ect_pkg::OUT_OVERFLOW : ect_pkg::OUT_FEW;
            state     <= S_STAT;
          end else begin
            pa    <= prev_x * mul_y;
            pb    <= mul_x * prev_y;
            state <= S_WIND;
          end
        end
        S_WIND: begin
          ccw     <= !area_total[AW-1];
          rem_cnt <= point_count;
          state   <= S_INIT;
        end
        S_INIT: begin
          state <= S_ALIGN;
        end
        S_ALIGN: begin
          if (h1) begin
            if (rem_cnt == CNT_W'(3)) begin
              if (out_free) begin
                result <= '{first_index: OIW'(i1), second_index: OIW'(i2),
                            third_index: OIW'(i0), has_triangle: 1'b1, end_of_run: 1'b1,
                            outcome: ovf ? ect_pkg::OUT_OVERFLOW : ect_pkg::OUT_COMPLETE};
                point_count <= '0;
                rem_cnt     <= '0;
                area        <= '0;
                ovf         <= 1'b0;
                state       <= S_LOAD;
              end
            end else begin
              scan  <= '0;
              ph    <= '0;
              state <= S_TEST;
            end
          end
        end
        S_TEST: begin
          if (ph != PH_DECIDE) begin
            ph <= ph + 3'd1;
          end else if (clip) begin
            if (out_free) begin
              if (ccw) begin
                result <= '{first_index: OIW'(i0), second_index: OIW'(i1),
                            third_index: OIW'(i2), has_triangle: 1'b1, end_of_run: 1'b0,
                            outcome: ect_pkg::OUT_COMPLETE};
              end else begin
                result <= '{first_index: OIW'(i2), second_index: OIW'(i0),
                            third_index: OIW'(i1), has_triangle: 1'b1, end_of_run: 1'b0,
                            outcome: ect_pkg::OUT_COMPLETE};
              end
              rem_cnt <= rem_cnt - CNT_W'(1);
              state   <= S_ALIGN;
            end
          end else if (last_scan) begin
            stat_code <= ovf ? ect_pkg::OUT_OVERFLOW : ect_pkg::OUT_DEGEN;
            state     <= S_STAT;
          end else begin
            scan <= scan + CNT_W'(1);
            ph   <= '0;
          end
        end
        S_STAT: begin
          if (out_free) begin
            result <= '{first_index: '0, second_index: '0, third_index: '0,
                        has_triangle: 1'b0, end_of_run: 1'b1, outcome: stat_code};
            point_count <= '0;
            rem_cnt     <= '0;
            area        <= '0;
            ovf         <= 1'b0;
            state       <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Ear-clip triangulator testbench
// Drives polygons into the triangulator and checks each reported triangle and
// status transaction against a behavioral ear-clipping predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int NPTS = 32;

  logic               clk;
  logic               rst;
  logic               vertex_valid;
  logic               vertex_stall;
  ect_pkg::in_item_t  vertex;
  logic               result_valid;
  logic               result_stall;
  ect_pkg::out_item_t result;

  ect_pkg::in_item_t  pending_vertices[$];
  ect_pkg::out_item_t expected_results[$];
  int                 error_count;

  logic signed [15:0] poly_x[NPTS];
  logic signed [15:0] poly_y[NPTS];
  int                 poly_count;
  bit                 poly_overflow;
  int                 walk[NPTS];
  int                 walk_len;

  int burst_left;
  int gap_left;
  int stall_mode;

  ear_clip_triangulator i_dut (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint corner_turn(int a, int b, int c);
    longint ax, ay, bx, by, cx, cy;
    ax = poly_x[a];
    ay = poly_y[a];
    bx = poly_x[b];
    by = poly_y[b];
    cx = poly_x[c];
    cy = poly_y[c];
    return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
  endfunction

  function automatic bit ear_blocked(int a, int b, int c);
    int k;
    for (int j = 0; j < walk_len; j++) begin
      k = walk[j];
      if (k != a && k != b && k != c && corner_turn(a, b, k) >= 0 &&
          corner_turn(b, c, k) >= 0 && corner_turn(c, a, k) >= 0)
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_result(int a, int b, int c, bit tri_flag, bit last,
                                      ect_pkg::outcome_t code);
    ect_pkg::out_item_t r;
    r.first_index  = a[4:0];
    r.second_index = b[4:0];
    r.third_index  = c[4:0];
    r.has_triangle = tri_flag;
    r.end_of_run   = last;
    r.outcome      = code;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void triangulate_polygon();
    longint area;
    bit     ccw;
    bit     clipped;
    int     a, b, c;
    area = 0;
    for (int i = 0; i < poly_count; i++) begin
      a = (i + 1) % poly_count;
      area += longint'(poly_x[i]) * poly_y[a] - longint'(poly_x[a]) * poly_y[i];
    end
    ccw = (area >= 0);
    for (int i = 0; i < poly_count; i++) walk[i] = ccw ? i : poly_count - 1 - i;
    walk_len = poly_count;
    while (walk_len > 3) begin
      clipped = 1'b0;
      for (int i = 0; i < walk_len && !clipped; i++) begin
        a = walk[(i + walk_len - 1) % walk_len];
        b = walk[i];
        c = walk[(i + 1) % walk_len];
        if (corner_turn(a, b, c) > 0 && !ear_blocked(a, b, c)) begin
          if (ccw) push_result(a, b, c, 1'b1, 1'b0, ect_pkg::OUT_COMPLETE);
          else push_result(a, c, b, 1'b1, 1'b0, ect_pkg::OUT_COMPLETE);
          for (int j = i; j < walk_len - 1; j++) walk[j] = walk[j + 1];
          walk_len--;
          clipped = 1'b1;
        end
      end
      if (!clipped) break;
    end
    if (walk_len == 3) begin
      if (ccw)
        push_result(walk[0], walk[1], walk[2], 1'b1, 1'b1,
                    poly_overflow ? ect_pkg::OUT_OVERFLOW : ect_pkg::OUT_COMPLETE);
      else
        push_result(walk[0], walk[2], walk[1], 1'b1, 1'b1,
                    poly_overflow ? ect_pkg::OUT_OVERFLOW : ect_pkg::OUT_COMPLETE);
    end else begin
      push_result(0, 0, 0, 1'b0, 1'b1,
                  poly_overflow ? ect_pkg::OUT_OVERFLOW : ect_pkg::OUT_DEGEN);
    end
  endfunction

  function automatic void predict_vertex(ect_pkg::in_item_t v);
    if (poly_count < NPTS) begin
      poly_x[poly_count] = v.point_x;
      poly_y[poly_count] = v.point_y;
      poly_count++;
    end else begin
      poly_overflow = 1'b1;
    end
    if (v.final_point) begin
      if (poly_count < 3)
        push_result(0, 0, 0, 1'b0, 1'b1,
                    poly_overflow ? ect_pkg::OUT_OVERFLOW : ect_pkg::OUT_FEW);
      else
        triangulate_polygon();
      poly_count    = 0;
      poly_overflow = 1'b0;
    end
  endfunction

  function automatic void add_vertex(int x, int y, bit last);
    ect_pkg::in_item_t v;
    v.point_x     = x[15:0];
    v.point_y     = y[15:0];
    v.final_point = last;
    pending_vertices.insert(pending_vertices.size(), v);
  endfunction

  function automatic void add_random_polygon(int n, int span);
    int    cx, cy, r, ang;
    real   th;
    bit    rev;
    cx  = $urandom_range(2 * (32767 - span), 0) - (32767 - span);
    cy  = $urandom_range(2 * (32767 - span), 0) - (32767 - span);
    rev = $urandom_range(1, 0);
    ang = 0;
    for (int i = 0; i < n; i++) begin
      ang += $urandom_range(2 * 3600 / n, 1);
      th = (rev ? -ang : ang) * 3.14159265 / 1800.0;
      r  = $urandom_range(span, span / 4 + 1);
      add_vertex(cx + $rtoi(r * $cos(th)), cy + $rtoi(r * $sin(th)), i == n - 1);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else if (!vertex_valid || !vertex_stall) begin
      if (vertex_valid) predict_vertex(vertex);
      if (gap_left > 0) begin
        gap_left     <= gap_left - 1;
        vertex_valid <= 1'b0;
      end else if (pending_vertices.size() > 0) begin
        vertex       <= pending_vertices.pop_front();
        vertex_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(12, 1);
          gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(4, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        vertex_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_mode   <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %p", $time, result);
          error_count++;
        end else if (result !== expected_results[0]) begin
          $display("%0t: mismatch expected %p actual %p", $time, expected_results[0], result);
          error_count++;
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      if ($urandom_range(63, 0) == 0) stall_mode <= $urandom_range(3, 0);
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(3, 0) == 0);
        2: result_stall <= ($urandom_range(1, 0) == 0);
        default: result_stall <= ($urandom_range(7, 0) != 0);
      endcase
    end
  end

  initial begin
    int n, total;
    rst           = 1'b1;
    vertex_valid  = 1'b0;
    result_stall  = 1'b0;
    vertex        = '0;
    error_count   = 0;
    poly_count    = 0;
    poly_overflow = 1'b0;

    // Fewer than three points, a single point, and a two-point polygon.
    add_vertex(-32768, 32767, 1'b1);
    add_vertex(32767, -32768, 1'b0);
    add_vertex(0, 0, 1'b1);
    // Extreme-coordinate triangle, counter-clockwise then clockwise.
    add_vertex(-32768, -32768, 1'b0);
    add_vertex(32767, -32768, 1'b0);
    add_vertex(32767, 32767, 1'b1);
    add_vertex(-32768, -32768, 1'b0);
    add_vertex(32767, 32767, 1'b0);
    add_vertex(32767, -32768, 1'b1);
    // Collinear points stop as degenerate.
    add_vertex(0, 0, 1'b0);
    add_vertex(1, 1, 1'b0);
    add_vertex(2, 2, 1'b0);
    add_vertex(3, 3, 1'b1);
    // Concave polygon with a reflex corner.
    add_vertex(0, 0, 1'b0);
    add_vertex(100, 0, 1'b0);
    add_vertex(50, 20, 1'b0);
    add_vertex(100, 100, 1'b0);
    add_vertex(0, 100, 1'b1);

    total = 0;
    while (total < 350) begin
      case ($urandom_range(9, 0))
        0: begin
          // Overflow: more than capacity, final point dropped too.
          n = NPTS + $urandom_range(3, 1);
          add_random_polygon(n, 200 + $urandom_range(20000, 0));
        end
        1: begin
          n = $urandom_range(6, 1);
          for (int i = 0; i < n; i++)
            add_vertex($urandom_range(65535, 0) - 32768, $urandom_range(65535, 0) - 32768,
                       i == n - 1);
        end
        2: begin
          n = $urandom_range(8, 3);
          for (int i = 0; i < n; i++)
            add_vertex($urandom_range(4, 0), $urandom_range(4, 0), i == n - 1);
        end
        default: begin
          n = $urandom_range(12, 3);
          add_random_polygon(n, 50 + $urandom_range(30000, 0));
        end
      endcase
      total += n;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending_vertices.size() != 0 || vertex_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> ear_clip_triangulator.f
rtl/ect_pkg.sv
rtl/ect_cell.sv
rtl/ear_clip_triangulator.sv
test/tb_top.sv
